[design/pie_pkg.sv]
// shared types and constants for the positional insert / edit array
// used by pie_cell and positional_insert_edit_array, no other dependencies
`default_nettype none

package pie_pkg;

  localparam int CAPACITY = 16;
  localparam int WORD_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int POS_W    = 4;
  localparam int STAT_W   = 2;
  localparam int CAPREG_W = 5;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [CAPREG_W-1:0] CAP_RESET = CAPREG_W'(16);

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_EDIT   = 2'd1,
    MODE_DUMP   = 2'd2
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_TAKE_LOWER,
    CELL_TAKE_UPPER,
    CELL_TAKE_HEAD
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t                 cmd;
    logic signed [WORD_W-1:0]  word;
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } ctl_state_t;

  // only register: capacity_in_use at byte address 0
  localparam logic REG_CAP = 1'b0;

endpackage

`default_nettype wire

[design/pie_cell.sv]
// one storage cell of the insert / edit chain
// depends on pie_pkg for the cell command and control struct
`default_nettype none

module pie_cell
  import pie_pkg::*;
(
  input  wire logic                       clk,
  input  wire cell_ctl_t                  ctl,
  input  wire logic signed [WORD_W-1:0]   lower,
  input  wire logic signed [WORD_W-1:0]   upper,
  input  wire logic signed [WORD_W-1:0]   head,
  output      logic signed [WORD_W-1:0]   data
);

  logic signed [WORD_W-1:0] data_r;
  logic signed [WORD_W-1:0] data_nxt;

  always_comb begin
    case (ctl.cmd)
      CELL_LOAD:       data_nxt = ctl.word;
      CELL_TAKE_LOWER: data_nxt = lower;
      CELL_TAKE_UPPER: data_nxt = upper;
      CELL_TAKE_HEAD:  data_nxt = head;
      default:         data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

[design/positional_insert_edit_array.sv]
// top level of the positional insert / edit array: register port, control and cell chain
// depends on pie_pkg and pie_cell
`default_nettype none

// Holds up to CAPACITY signed 32-bit words in a chain of cells. An insert or an
// edit gives one status transaction; the cells shift up in parallel on insert.
// A dump of n stored words gives n transactions (one when empty): each cycle
// that the output is free, the chain rotates its first n cells down by one and
// the head cell is emitted, so after the dump the order is as before. No new
// input transaction is taken during a dump. Mode 3 is dropped without a result.
// capacity_in_use sits at byte address 0 and should be written only while the
// block is idle; the block itself does not enforce this.
module positional_insert_edit_array
  import pie_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,

  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic [1:0]                 in_mode,
  input  wire logic [POS_W-1:0]           in_position,
  input  wire logic signed [WORD_W-1:0]   in_word_in,

  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic [STAT_W-1:0]          out_status,
  output      logic signed [WORD_W-1:0]   out_word_out,
  output      logic [POS_W-1:0]           out_entry_index,
  output      logic [CAPREG_W-1:0]        out_entry_count,
  output      logic                       out_last,

  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [PADDR_W-1:0]         paddr,
  input  wire logic [PDATA_W-1:0]         pwdata,
  output      logic [PDATA_W-1:0]         prdata,
  output      logic                       pready
);

  // configuration register
  logic [CAPREG_W-1:0] cap_r;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAP);
  assign prdata = (paddr[2] == REG_CAP) ? PDATA_W'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= pwdata[CAPREG_W-1:0];
    end
  end

  // control state
  ctl_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   dump_idx_r, dump_idx_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic signed [WORD_W-1:0] out_word_r, out_word_nxt;
  logic [POS_W-1:0]   out_index_r, out_index_nxt;
  logic [CAPREG_W-1:0] out_count_r, out_count_nxt;
  logic               out_last_r, out_last_nxt;

  logic               out_free;
  logic               accept;
  logic               dump_step;
  logic               dump_last;
  logic [CNT_W-1:0]   limit;
  logic               is_full;
  logic               ins_ok;
  logic               edt_ok;
  mode_t              mode;

  logic signed [WORD_W-1:0] cell_data [CAPACITY];

  assign mode     = mode_t'(in_mode);
  assign out_free = !out_valid_r || !out_stall;
  assign accept   = in_valid && !in_stall;
  assign limit    = (32'(cap_r) > 32'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(cap_r);
  assign is_full  = (count_r >= limit);
  assign ins_ok   = (mode == MODE_INSERT) && !is_full &&
                    (32'(in_position) <= 32'(count_r));
  assign edt_ok   = (mode == MODE_EDIT) && (32'(in_position) < 32'(count_r));
  assign dump_last = (CNT_W'(dump_idx_r) + CNT_W'(1)) == count_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (mode == MODE_DUMP) && (count_r != '0)) begin
          state_nxt = S_DUMP;
        end
      end
      S_DUMP: begin
        if (dump_step && dump_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    dump_step = 1'b0;
    unique case (state_r)
      S_IDLE: in_stall = !out_free;
      S_DUMP: dump_step = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  // counters and result register
  always_comb begin
    count_nxt      = count_r;
    dump_idx_nxt   = dump_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_word_nxt   = out_word_r;
    out_index_nxt  = out_index_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;

    if (accept) begin
      dump_idx_nxt  = '0;
      out_word_nxt  = '0;
      out_index_nxt = '0;
      out_last_nxt  = 1'b1;
      out_count_nxt = CAPREG_W'(count_r);
      case (mode)
        MODE_INSERT: begin
          out_valid_nxt = 1'b1;
          if (is_full) begin
            out_status_nxt = STAT_FULL;
          end else if (!ins_ok) begin
            out_status_nxt = STAT_BADPOS;
          end else begin
            out_status_nxt = STAT_OK;
            count_nxt      = count_r + CNT_W'(1);
            out_count_nxt  = CAPREG_W'(count_r + CNT_W'(1));
          end
        end
        MODE_EDIT: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = edt_ok ? STAT_OK : STAT_BADPOS;
        end
        MODE_DUMP: begin
          // a non-empty dump emits from the dump state
          if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_EMPTY;
          end
        end
        default: ;
      endcase
    end else if (dump_step) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = STAT_OK;
      out_word_nxt   = cell_data[0];
      out_index_nxt  = POS_W'(dump_idx_r);
      out_count_nxt  = CAPREG_W'(count_r);
      out_last_nxt   = dump_last;
      dump_idx_nxt   = dump_idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_word_r   <= out_word_nxt;
    out_index_r  <= out_index_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_word_out    = out_word_r;
  assign out_entry_index = out_index_r;
  assign out_entry_count = out_count_r;
  assign out_last        = out_last_r;

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t                ctl;
    logic signed [WORD_W-1:0] lower;
    logic signed [WORD_W-1:0] upper;
    logic                     at_pos;
    logic                     is_tail;
    logic                     below_tail;

    assign at_pos     = (32'(in_position) == i);
    assign is_tail    = (CNT_W'(i) + CNT_W'(1)) == count_r;
    assign below_tail = (CNT_W'(i) + CNT_W'(1)) < count_r;

    if (i == 0) begin : g_first
      assign lower = cell_data[i];
    end else begin : g_lower
      assign lower = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign upper = cell_data[i];
    end else begin : g_upper
      assign upper = cell_data[i+1];
    end

    always_comb begin
      ctl.word = in_word_in;
      ctl.cmd  = CELL_HOLD;
      if (accept && ins_ok) begin
        if (at_pos) begin
          ctl.cmd = CELL_LOAD;
        end else if (32'(in_position) < i) begin
          ctl.cmd = CELL_TAKE_LOWER;
        end
      end else if (accept && edt_ok && at_pos) begin
        ctl.cmd = CELL_LOAD;
      end else if (dump_step) begin
        // rotate the stored words down, head wraps to the tail
        if (is_tail) begin
          ctl.cmd = CELL_TAKE_HEAD;
        end else if (below_tail) begin
          ctl.cmd = CELL_TAKE_UPPER;
        end
      end
    end

    pie_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .lower (lower),
      .upper (upper),
      .head  (cell_data[0]),
      .data  (cell_data[i])
    );
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_dump_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> (CNT_W'(dump_idx_r) < count_r))
    else $error("dump index past stored entries");

  a_dump_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> in_stall)
    else $error("input taken during dump");

  a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (mode == MODE_INSERT) && is_full) |=> $stable(count_r))
    else $error("refused insert changed the count");

  a_dump_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DUMP) && dump_step && dump_last) |=> (out_valid_r && out_last_r))
    else $error("final dump transaction without last");
`endif

endmodule

`default_nettype wire
